@@ src/hpx_pkg.sv @@
package hpx_pkg;

  localparam int NSIDE_W   = 14;
  localparam int MAX_NSIDE = 8192;
  localparam int PIX_W     = 30;
  localparam int RING_W    = 15;
  localparam int RPOS_W    = 16;
  localparam int OPOS_W    = 15;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEPS     = 15;
  localparam int BACK_N    = 6;

  localparam logic CMD_PIX2RING = 1'b0;
  localparam logic CMD_RING2PIX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NSIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFTED = 2'd1;

  typedef enum logic [1:0] {
    REG_CAP,
    REG_EQ,
    REG_SOUTH
  } region_t;

  typedef struct packed {
    logic [NSIDE_W-1:0] nside;
    logic [LEN_W-1:0]   nring;
    logic [PIX_W-1:0]   npix;
    logic [PIX_W-1:0]   ncap;
    logic [PIX_W-1:0]   eqend;
    logic               shifted;
  } geom_t;

  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic              ok;
    region_t           region;
    logic [PIX_W-1:0]  p;
    logic [RING_W-1:0] ring;
    logic [RPOS_W-1:0] rpos;
    logic [PIX_W-1:0]  sq_x;
    logic [PIX_W-1:0]  sq_res;
    logic [PIX_W-1:0]  dv_rem;
    logic [RING_W-1:0] dv_q;
  } front_t;

  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic              ok;
    logic              south;
    logic              iscap;
    logic [PIX_W-1:0]  p;
    logic [LEN_W-1:0]  r;
    logic [RPOS_W-1:0] rpos;
    logic [RING_W-1:0] ma;
    logic [RING_W-1:0] mb;
    logic [PIX_W-1:0]  prod;
    logic [PIX_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
  } back_t;

  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [PIX_W-1:0]  pixel;
    logic [RING_W-1:0] ring;
    logic [OPOS_W-1:0] rpos;
  } res_t;

endpackage

@@ src/healpix_ring_pixel_index.sv @@
// throughput: one word per cycle unless out_stall holds the skid word;
// 15 root/divide stages plus the ring span stages and the output register
// with a one-word skid set the depth
// reset (synchronous, rst_n low): nside 1, shifted 0, pipeline and output empty
module healpix_ring_pixel_index import hpx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NSIDE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic [RING_W-1:0]    in_ring,
  input  logic [RPOS_W-1:0]    in_ring_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_valid_res,
  output logic [PIX_W-1:0]     out_pixel,
  output logic [RING_W-1:0]    out_ring,
  output logic [OPOS_W-1:0]    out_ring_pixel
);

  geom_t  geom;
  front_t fo;
  res_t   tail;
  logic   adv;

  hpx_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .geom(geom)
  );

  hpx_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
    .in_command(in_command), .in_pixel(in_pixel), .in_ring(in_ring),
    .in_ring_pixel(in_ring_pixel), .geom(geom), .fo(fo)
  );

  hpx_span u_span (
    .clk(clk), .rst_n(rst_n), .adv(adv), .fo(fo), .geom(geom), .tail(tail)
  );

  hpx_out u_out (
    .clk(clk), .rst_n(rst_n), .tail(tail), .out_stall(out_stall), .adv(adv),
    .out_valid(out_valid), .out_valid_res(out_valid_res), .out_pixel(out_pixel),
    .out_ring(out_ring), .out_ring_pixel(out_ring_pixel)
  );

  assign in_stall = !adv;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_pixel == '0 && out_ring == '0 && out_ring_pixel == '0))
    else $error("invalid word carries nonzero fields");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res && out_ring != '0) |-> (out_pixel == '0))
    else $error("word carries both pixel and ring");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without an output stall");

endmodule

@@ src/hpx_cfg.sv @@
module hpx_cfg import hpx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NSIDE_W-1:0]   cfg_data,
  output geom_t                geom
);

  logic [NSIDE_W-1:0] nside_r, nside_nxt;
  logic               shifted_r, shifted_nxt;
  logic [LEN_W-1:0]   nring_r;
  logic [PIX_W-1:0]   npix_r, ncap_r, eqend_r;
  logic [2*NSIDE_W-1:0] sq;
  logic [PIX_W-1:0]   npix_nxt, ncap_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    nside_nxt   = nside_r;
    shifted_nxt = shifted_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NSIDE: begin
          // saturate oversized grids
          if (cfg_data > NSIDE_W'(MAX_NSIDE)) nside_nxt = NSIDE_W'(MAX_NSIDE);
          else nside_nxt = cfg_data;
        end
        CFG_SHIFTED: shifted_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sq       = (2*NSIDE_W)'(nside_r) * (2*NSIDE_W)'(nside_r);
    npix_nxt = (PIX_W'(sq) << 3) + (PIX_W'(sq) << 2);
    ncap_nxt = (PIX_W'(sq) - PIX_W'(nside_r)) << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nside_r   <= NSIDE_W'(1);
      shifted_r <= 1'b0;
      nring_r   <= LEN_W'(4);
      npix_r    <= PIX_W'(12);
      ncap_r    <= '0;
      eqend_r   <= PIX_W'(12);
    end else begin
      nside_r   <= nside_nxt;
      shifted_r <= shifted_nxt;
      nring_r   <= LEN_W'(nside_r) << 2;
      npix_r    <= npix_nxt;
      ncap_r    <= ncap_nxt;
      eqend_r   <= npix_nxt - ncap_nxt;
    end
  end

  assign geom = '{nside: nside_r, nring: nring_r, npix: npix_r, ncap: ncap_r,
                  eqend: eqend_r, shifted: shifted_r};

endmodule

@@ src/hpx_front.sv @@
module hpx_front import hpx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic              in_command,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [RING_W-1:0] in_ring,
  input  logic [RPOS_W-1:0] in_ring_pixel,
  input  geom_t             geom,
  output front_t            fo
);

  front_t s0_r;
  front_t st_r [STEPS+1];
  front_t st_nxt [STEPS+1];
  logic [PIX_W-1:0] v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (adv) begin
      s0_r.vld    <= in_valid;
      s0_r.cmd    <= in_command;
      s0_r.p      <= in_pixel;
      s0_r.ring   <= in_ring;
      s0_r.rpos   <= in_ring_pixel;
      s0_r.ok     <= 1'b0;
      s0_r.region <= REG_EQ;
      s0_r.sq_x   <= '0;
      s0_r.sq_res <= '0;
      s0_r.dv_rem <= '0;
      s0_r.dv_q   <= '0;
    end
  end

  // region split and set-up of root and divide operands
  always_comb begin
    st_nxt[0]        = s0_r;
    st_nxt[0].ok     = (geom.nside != '0);
    st_nxt[0].region = REG_EQ;
    st_nxt[0].sq_res = '0;
    st_nxt[0].dv_q   = '0;
    st_nxt[0].dv_rem = '0;
    v                = '0;
    if (s0_r.cmd == CMD_PIX2RING) begin
      st_nxt[0].ok = st_nxt[0].ok && (s0_r.p < geom.npix);
      if (s0_r.p < geom.ncap) begin
        st_nxt[0].region = REG_CAP;
        v = s0_r.p;
      end else if (s0_r.p >= geom.eqend) begin
        st_nxt[0].region = REG_SOUTH;
        v = geom.npix - s0_r.p - PIX_W'(1);
      end else begin
        st_nxt[0].dv_rem = s0_r.p - geom.ncap;
      end
    end
    st_nxt[0].sq_x = {v[PIX_W-2:0], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r[0].vld <= 1'b0;
    else if (adv) st_r[0] <= st_nxt[0];
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam int SH = STEPS - 1 - g;
    logic [PIX_W:0] sbit, stry, dsh;
    always_comb begin
      st_nxt[g+1] = st_r[g];
      // one root digit
      sbit = (PIX_W+1)'(1) << (2*SH);
      stry = {1'b0, st_r[g].sq_res} + sbit;
      if ({1'b0, st_r[g].sq_x} >= stry) begin
        st_nxt[g+1].sq_x   = st_r[g].sq_x - PIX_W'(stry);
        st_nxt[g+1].sq_res = (st_r[g].sq_res >> 1) + PIX_W'(sbit);
      end else begin
        st_nxt[g+1].sq_res = st_r[g].sq_res >> 1;
      end
      // one quotient bit
      dsh = (PIX_W+1)'(geom.nring) << SH;
      if ({1'b0, st_r[g].dv_rem} >= dsh) begin
        st_nxt[g+1].dv_rem   = st_r[g].dv_rem - PIX_W'(dsh);
        st_nxt[g+1].dv_q[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) st_r[g+1].vld <= 1'b0;
      else if (adv) st_r[g+1] <= st_nxt[g+1];
    end
  end

  assign fo = st_r[STEPS];

endmodule

@@ src/hpx_span.sv @@
module hpx_span import hpx_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  front_t fo,
  input  geom_t  geom,
  output res_t   tail
);

  back_t bk_r [BACK_N];
  back_t bk_nxt [BACK_N];
  res_t  res_r, res_nxt;
  logic [LEN_W-1:0] csq, r, k;
  logic [LEN_W:0]   t;
  logic [PIX_W:0]   psum;
  logic [PIX_W-1:0] rel;

  // ring number, fold to north, pick multiplier operands
  always_comb begin
    csq = LEN_W'((fo.sq_res + PIX_W'(1)) >> 1);
    if (fo.cmd == CMD_RING2PIX) begin
      r = LEN_W'(fo.ring);
    end else begin
      case (fo.region)
        REG_CAP:   r = csq;
        REG_SOUTH: r = geom.nring - csq;
        default:   r = LEN_W'(fo.dv_q) + LEN_W'(geom.nside);
      endcase
    end
    bk_nxt[0]       = '0;
    bk_nxt[0].vld   = fo.vld;
    bk_nxt[0].cmd   = fo.cmd;
    bk_nxt[0].p     = fo.p;
    bk_nxt[0].rpos  = fo.rpos;
    bk_nxt[0].r     = r;
    bk_nxt[0].ok    = fo.ok && (r != '0) && (r < geom.nring);
    bk_nxt[0].south = r > (LEN_W'(geom.nside) << 1);
    k               = bk_nxt[0].south ? geom.nring - r : r;
    bk_nxt[0].iscap = k < LEN_W'(geom.nside);
    if (bk_nxt[0].iscap) begin
      bk_nxt[0].ma  = RING_W'(k);
      bk_nxt[0].mb  = RING_W'(k - LEN_W'(1));
      bk_nxt[0].len = k << 2;
    end else begin
      bk_nxt[0].ma  = RING_W'(k - LEN_W'(geom.nside));
      bk_nxt[0].mb  = RING_W'(geom.nside);
      bk_nxt[0].len = geom.nring;
    end
  end

  always_comb begin
    bk_nxt[1]      = bk_r[0];
    bk_nxt[1].prod = PIX_W'(bk_r[0].ma) * PIX_W'(bk_r[0].mb);
  end

  always_comb begin
    bk_nxt[2] = bk_r[1];
    if (bk_r[1].iscap) bk_nxt[2].start = bk_r[1].prod << 1;
    else bk_nxt[2].start = geom.ncap + (bk_r[1].prod << 2);
  end

  // southern rings mirror the northern ones
  always_comb begin
    bk_nxt[3] = bk_r[2];
    if (bk_r[2].south)
      bk_nxt[3].start = geom.npix - bk_r[2].start - PIX_W'(bk_r[2].len);
  end

  always_comb begin
    bk_nxt[4] = bk_r[3];
    rel       = bk_r[3].p - bk_r[3].start;
    if (bk_r[3].cmd == CMD_PIX2RING) begin
      bk_nxt[4].ok  = bk_r[3].ok && (bk_r[3].p >= bk_r[3].start) &&
                      (rel < PIX_W'(bk_r[3].len));
      bk_nxt[4].pos = LEN_W'(rel);
    end else begin
      bk_nxt[4].ok  = bk_r[3].ok && (bk_r[3].rpos < bk_r[3].len);
      bk_nxt[4].pos = bk_r[3].rpos;
    end
  end

  // half-ring rotation if shifted, sum below twice the length
  always_comb begin
    bk_nxt[5] = bk_r[4];
    t = (LEN_W+1)'(bk_r[4].pos) + (LEN_W+1)'(bk_r[4].len >> 1);
    if (t >= (LEN_W+1)'(bk_r[4].len)) t = t - (LEN_W+1)'(bk_r[4].len);
    if (geom.shifted) bk_nxt[5].pos = LEN_W'(t);
  end

  for (genvar j = 0; j < BACK_N; j++) begin : g_bk
    always_ff @(posedge clk) begin
      if (!rst_n) bk_r[j].vld <= 1'b0;
      else if (adv) bk_r[j] <= bk_nxt[j];
    end
  end

  always_comb begin
    psum        = (PIX_W+1)'(bk_r[5].start) + (PIX_W+1)'(bk_r[5].pos);
    res_nxt     = '0;
    res_nxt.vld = bk_r[5].vld;
    if (bk_r[5].cmd == CMD_RING2PIX) begin
      res_nxt.ok = bk_r[5].ok && (psum < (PIX_W+1)'(geom.npix));
      if (res_nxt.ok) res_nxt.pixel = PIX_W'(psum);
    end else begin
      res_nxt.ok = bk_r[5].ok;
      if (res_nxt.ok) begin
        res_nxt.ring = RING_W'(bk_r[5].r);
        res_nxt.rpos = OPOS_W'(bk_r[5].pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_r.vld <= 1'b0;
    else if (adv) res_r <= res_nxt;
  end

  assign tail = res_r;

endmodule

@@ src/hpx_out.sv @@
module hpx_out import hpx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  res_t              tail,
  input  logic              out_stall,
  output logic              adv,
  output logic              out_valid,
  output logic              out_valid_res,
  output logic [PIX_W-1:0]  out_pixel,
  output logic [RING_W-1:0] out_ring,
  output logic [OPOS_W-1:0] out_ring_pixel
);

  res_t out_r, skid_r;
  logic take;

  assign take = out_r.vld && !out_stall;
  // pipeline freezes only while the skid word is held
  assign adv  = !skid_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld  <= 1'b0;
      skid_r.vld <= 1'b0;
    end else if (skid_r.vld) begin
      if (take) begin
        out_r      <= skid_r;
        skid_r.vld <= 1'b0;
      end
    end else if (tail.vld) begin
      if (!out_r.vld || take) out_r <= tail;
      else skid_r <= tail;
    end else if (take) begin
      out_r.vld <= 1'b0;
    end
  end

  assign out_valid      = out_r.vld;
  assign out_valid_res  = out_r.ok;
  assign out_pixel      = out_r.pixel;
  assign out_ring       = out_r.ring;
  assign out_ring_pixel = out_r.rpos;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hpx_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NSIDE;
  logic [NSIDE_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_command = CMD_PIX2RING;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic [RING_W-1:0]    in_ring = '0;
  logic [RPOS_W-1:0]    in_ring_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_valid_res;
  logic [PIX_W-1:0]     out_pixel;
  logic [RING_W-1:0]    out_ring;
  logic [OPOS_W-1:0]    out_ring_pixel;

  typedef struct packed {
    logic              ok;
    logic [PIX_W-1:0]  pixel;
    logic [RING_W-1:0] ring;
    logic [OPOS_W-1:0] rpos;
  } conv_t;

  conv_t       pending_q[$];
  longint      grid_nside = 1;
  bit          grid_shifted = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  longint      cycles = 0;
  localparam longint CYCLE_LIMIT = 400000;

  healpix_ring_pixel_index i_dut (.*);

  always #6 clk = ~clk;

  function automatic longint int_sqrt(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r = r + 1;
    return r;
  endfunction

  // ring number of a cap pixel: largest k with 2k(k-1) <= v
  function automatic longint cap_ring_of(longint v);
    longint k;
    k = (1 + int_sqrt(1 + 2 * v)) / 2;
    while (2 * k * (k - 1) > v) k = k - 1;
    while (2 * (k + 1) * k <= v) k = k + 1;
    return k;
  endfunction

  function automatic void span_of(longint r, output longint s, output longint l);
    longint k;
    bit     south;
    south = r > 2 * grid_nside;
    k = south ? 4 * grid_nside - r : r;
    if (k < grid_nside) begin
      l = 4 * k;
      s = 2 * k * (k - 1);
    end else begin
      l = 4 * grid_nside;
      s = 2 * grid_nside * (grid_nside - 1) + (k - grid_nside) * l;
    end
    if (south) s = 12 * grid_nside * grid_nside - s - l;
  endfunction

  function automatic conv_t convert(logic cmd, longint p, longint r, longint pos);
    conv_t  c;
    longint nring, npix, ncap, s, l;
    c = '0;
    nring = 4 * grid_nside;
    npix = 12 * grid_nside * grid_nside;
    ncap = 2 * grid_nside * (grid_nside - 1);
    if (grid_nside == 0) return c;
    if (cmd == CMD_PIX2RING) begin
      if (p >= npix) return c;
      if (p < ncap) r = cap_ring_of(p);
      else if (p < npix - ncap) r = (p - ncap) / nring + grid_nside;
      else r = nring - cap_ring_of(npix - p - 1);
      if (r == 0 || r >= nring) return c;
      span_of(r, s, l);
      if (p < s || p - s >= l) return c;
      pos = p - s;
      if (grid_shifted) pos = (pos + l / 2) % l;
      c.ok = 1'b1;
      c.ring = r[RING_W-1:0];
      c.rpos = pos[OPOS_W-1:0];
    end else begin
      if (r == 0 || r >= nring) return c;
      span_of(r, s, l);
      if (l == 0 || pos >= l) return c;
      if (grid_shifted) pos = (pos + l / 2) % l;
      p = s + pos;
      if (p >= npix) return c;
      c.ok = 1'b1;
      c.pixel = p[PIX_W-1:0];
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NSIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_NSIDE) grid_nside = (val > MAX_NSIDE) ? MAX_NSIDE : val;
    else grid_shifted = val[0];
  endtask

  task automatic set_grid(int ns, bit sh);
    wait_drained();
    write_reg(CFG_NSIDE, ns[NSIDE_W-1:0]);
    write_reg(CFG_SHIFTED, {{(NSIDE_W-1){1'b0}}, sh});
    @(posedge clk);
  endtask

  // one word; valid stays high into the next call when no gap follows
  task automatic send_word(logic cmd, logic [PIX_W-1:0] p, logic [RING_W-1:0] r,
                           logic [RPOS_W-1:0] pos, bit gap);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel <= p;
    in_ring <= r;
    in_ring_pixel <= pos;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(convert(cmd, p, r, pos));
    words_sent++;
    if (gap) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic random_word(int mode);
    longint npix, nring, r, s, l;
    logic [PIX_W-1:0] p;
    logic [RING_W-1:0] rg;
    logic [RPOS_W-1:0] pos;
    logic cmd;
    npix = 12 * grid_nside * grid_nside;
    nring = 4 * grid_nside;
    cmd = 1'($urandom_range(0, 1));
    p = PIX_W'($urandom);
    rg = RING_W'($urandom);
    pos = RPOS_W'($urandom);
    if (mode < 8 && grid_nside > 0) begin
      p = PIX_W'($urandom_range(0, npix - 1));
      r = $urandom_range(1, nring - 1);
      rg = r[RING_W-1:0];
      span_of(r, s, l);
      pos = (mode == 0) ? RPOS_W'(l - 1) : RPOS_W'($urandom_range(0, l - 1));
    end
    send_word(cmd, p, rg, pos, $urandom_range(0, 5) == 0);
  endtask

  task automatic test_edges();
    set_grid(1, 0);
    send_word(CMD_PIX2RING, 0, 0, 0, 0);
    send_word(CMD_PIX2RING, 11, 0, 0, 0);
    send_word(CMD_PIX2RING, 12, 0, 0, 0);
    send_word(CMD_RING2PIX, 0, 1, 3, 0);
    send_word(CMD_RING2PIX, 0, 0, 0, 1);
    set_grid(4, 1);
    send_word(CMD_PIX2RING, 0, 0, 0, 0);
    send_word(CMD_PIX2RING, 191, 0, 0, 0);
    send_word(CMD_PIX2RING, '1, 0, 0, 0);
    send_word(CMD_RING2PIX, '1, 15, 3, 0);
    send_word(CMD_RING2PIX, 0, 16, 0, 0);
    send_word(CMD_RING2PIX, 0, '1, '1, 0);
    send_word(CMD_RING2PIX, 0, 8, 16, 0);
    send_word(CMD_RING2PIX, 0, 2, 7, 1);
    set_grid(0, 0);
    send_word(CMD_PIX2RING, 0, 0, 0, 0);
    send_word(CMD_RING2PIX, 0, 1, 0, 1);
    set_grid(16383, 1);
    send_word(CMD_PIX2RING, 805306367, 0, 0, 0);
    send_word(CMD_PIX2RING, 805306368, 0, 0, 0);
    send_word(CMD_RING2PIX, 0, 32767, 0, 0);
    send_word(CMD_RING2PIX, 0, 16384, 32767, 0);
    send_word(CMD_RING2PIX, 0, 32767, 3, 1);
  endtask

  task automatic test_random();
    int sizes[8] = '{1, 2, 3, 5, 17, 100, 4096, 8192};
    for (int ph = 0; ph < 10; ph++) begin
      set_grid(sizes[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
      for (int n = 0; n < 48; n++) begin
        random_word($urandom_range(0, 9));
        // hold off until the pipe is empty
        if (ph == 4 && n == 20) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      in_valid <= 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_random();
    wait_drained();
    $display("%0d words sent, %0d results checked over several grid sizes and both modes",
             words_sent, results_seen);
    if (mismatches == 0) $display("healpix_ring_pixel_index: match");
    else $display("healpix_ring_pixel_index: mismatch");
    $finish;
  end

  // receiver stall pattern with quiet stretches
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= (cycles % 512 < 128) ? 1'b0 : ($urandom_range(0, 3) == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("healpix_ring_pixel_index: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    conv_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (want.ok !== out_valid_res || want.pixel !== out_pixel ||
            want.ring !== out_ring || want.rpos !== out_ring_pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("want ok %0b pix %0d ring %0d pos %0d, got %0b %0d %0d %0d",
                     want.ok, want.pixel, want.ring, want.rpos,
                     out_valid_res, out_pixel, out_ring, out_ring_pixel);
        end
      end
    end
  end

endmodule
